// ===== rtl/bsti_pkg.sv =====
// ----------------------------------------------------------------------------
// bsti_pkg - shared types and constants for the SoC table interpolator
// Field widths, result codes and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
`default_nettype none

package bsti_pkg;

   localparam int DATA_W          = 16;   // raw gauge reading / table entry
   localparam int CNT_W           = 6;    // entry count, entry index, segment index
   localparam int PCT_W           = 8;    // percent result
   localparam int MAX_ENTRIES_DEF = 64;

   // (i+1)*d <= 62*65535 fits 22 bits; times 100 fits 29 bits
   localparam int PROD_W = 22;
   localparam int NUM_W  = 29;
   localparam int QUOT_W = 7;             // quotient is always below 100
   localparam int STEP_W = 3;

   localparam logic [CNT_W-1:0]  DIRECT_BELOW = 6'd11;
   localparam logic [PCT_W-1:0]  FULL_PERCENT = 8'd100;
   localparam logic [QUOT_W-1:0] SCALE        = 7'd100;
   localparam logic [STEP_W-1:0] TOP_STEP     = 3'd6;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef enum logic [2:0] {
      RD_NONE,
      RD_FIRST,
      RD_LAST,
      RD_ONE,
      RD_NEXT
   } rd_sel_type;

   typedef enum logic [1:0] {
      RES_DIRECT,
      RES_ZERO,
      RES_FULL,
      RES_QUOT
   } res_sel_type;

   typedef struct packed {
      logic        wr_en;
      logic        cap;
      rd_sel_type  rd_sel;
      logic        keep_prev;
      logic        j_init;
      logic        j_inc;
      logic        take_seg;
      logic        calc_diff;
      logic        calc_mul;
      logic        calc_sum;
      logic        div_step;
      logic        finish;
      res_sel_type res_sel;
   } dp_cmd_type;

   typedef struct packed {
      logic n_small;    // fewer than DIRECT_BELOW entries in use
      logic raw_le_rd;  // raw <= entry just read
      logic raw_ge_rd;  // raw >= entry just read
      logic j_last;     // scan index at last entry
      logic div_last;   // final quotient bit
   } dp_status_type;

endpackage

`default_nettype wire

// ===== rtl/battery_soc_table_interpolator.sv =====
// ----------------------------------------------------------------------------
// battery_soc_table_interpolator - table-based state-of-charge interpolator
// Maps a raw fuel-gauge reading onto whole percent through a calibration
// table of increasing readings at equal state-of-charge steps.
// ----------------------------------------------------------------------------
// Usage: raise start with the request fields while busy is low. A write
// request (req_cmd = 0) stores req_entry_value at req_entry_index, returns
// nothing and leaves busy low. A query request (req_cmd = 1) returns exactly
// one percent on rsp_percent, marked by a one-cycle rsp_valid strobe; the
// receiver cannot stall, so capture it in that cycle. With fewer than 11
// entries in use (csr_write_data written while idle) the gauge's own
// req_direct_percent comes back in the cycle after start and busy never
// rises. Otherwise the query reads the first and last entries (clamps to 0
// or 100), scans segments one table read per cycle, then takes the
// difference and multiplies, runs a restoring divide (the quotient is
// always below 100) and loads the result. The single table read port sets
// the scan length. Writes beyond the table depth are dropped. Table entries
// are not reset; read only entries that were written.
// ----------------------------------------------------------------------------
`default_nettype none

module battery_soc_table_interpolator #(
   parameter int MAX_ENTRIES = bsti_pkg::MAX_ENTRIES_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // request channel
   input  wire logic                        start,
   output      logic                        busy,
   input  wire logic                        req_cmd,
   input  wire logic [bsti_pkg::CNT_W-1:0]  req_entry_index,
   input  wire logic [bsti_pkg::DATA_W-1:0] req_entry_value,
   input  wire logic [bsti_pkg::DATA_W-1:0] req_raw_reading,
   input  wire logic [bsti_pkg::PCT_W-1:0]  req_direct_percent,
   // result channel, one-cycle strobe
   output      logic                        rsp_valid,
   output      logic [bsti_pkg::PCT_W-1:0]  rsp_percent,
   // entry count register
   input  wire logic                        csr_write_en,
   input  wire logic [bsti_pkg::CNT_W-1:0]  csr_write_data
);

   import bsti_pkg::*;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   // sequencer: states for the table reads and the arithmetic steps
   bsti_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .req_cmd (req_cmd),
      .busy    (busy),
      .cmd     (dp_cmd),
      .status  (dp_status)
   );

   // datapath: table RAM, count register, search and divide registers
   bsti_dp #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (dp_cmd),
      .status             (dp_status),
      .req_entry_index    (req_entry_index),
      .req_entry_value    (req_entry_value),
      .req_raw_reading    (req_raw_reading),
      .req_direct_percent (req_direct_percent),
      .csr_write_en       (csr_write_en),
      .csr_write_data     (csr_write_data),
      .rsp_valid          (rsp_valid),
      .rsp_percent        (rsp_percent)
   );

endmodule

`default_nettype wire

// ===== rtl/bsti_ram.sv =====
// ----------------------------------------------------------------------------
// bsti_ram - generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bsti_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/bsti_dp.sv =====
// ----------------------------------------------------------------------------
// bsti_dp - datapath of the SoC table interpolator
// Table RAM, entry count register, segment search registers, multiply and
// restoring divide, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bsti_dp #(
   parameter int MAX_ENTRIES = bsti_pkg::MAX_ENTRIES_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire bsti_pkg::dp_cmd_type        cmd,
   output      bsti_pkg::dp_status_type     status,
   input  wire logic [bsti_pkg::CNT_W-1:0]  req_entry_index,
   input  wire logic [bsti_pkg::DATA_W-1:0] req_entry_value,
   input  wire logic [bsti_pkg::DATA_W-1:0] req_raw_reading,
   input  wire logic [bsti_pkg::PCT_W-1:0]  req_direct_percent,
   input  wire logic                        csr_write_en,
   input  wire logic [bsti_pkg::CNT_W-1:0]  csr_write_data,
   output      logic                        rsp_valid,
   output      logic [bsti_pkg::PCT_W-1:0]  rsp_percent
);

   import bsti_pkg::*;

   localparam int AW     = $clog2(MAX_ENTRIES);
   localparam int NCLAMP = (MAX_ENTRIES > 63) ? 63 : MAX_ENTRIES;
   localparam logic [CNT_W-1:0] N_MAX = CNT_W'(NCLAMP);
   localparam logic [8:0]       MAX_W = 9'(MAX_ENTRIES);

   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  n_live;
   logic [CNT_W-1:0]  n_ff;
   logic [DATA_W-1:0] raw_ff;
   logic [DATA_W-1:0] prev_ff;
   logic [DATA_W-1:0] hi_ff;
   logic [CNT_W-1:0]  j_ff;
   logic [CNT_W-1:0]  i_ff;
   logic [DATA_W-1:0] d_ff;
   logic [DATA_W-1:0] diff_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] den_ff;
   logic [NUM_W-1:0]  rem_ff;
   logic [QUOT_W-1:0] quot_ff;
   logic [STEP_W-1:0] k_ff;
   logic              rsp_valid_ff;
   logic [PCT_W-1:0]  percent_ff;
   logic [PCT_W-1:0]  percent_in;

   logic [DATA_W-1:0] rd_data;
   logic [CNT_W-1:0]  rd_idx;
   logic [AW+CNT_W-1:0] rd_wide;
   logic [AW+CNT_W-1:0] wr_wide;
   logic              wr_ok;
   logic [PROD_W-1:0] sum;
   logic [NUM_W-1:0]  trial;
   logic              fits;

   // entries in use, saturated at the smaller of table depth and 63
   assign n_live = (count_ff > N_MAX) ? N_MAX : count_ff;

   always_comb begin
      case (cmd.rd_sel)
         RD_FIRST: rd_idx = '0;
         RD_LAST:  rd_idx = n_ff - 6'd1;
         RD_ONE:   rd_idx = 6'd1;
         RD_NEXT:  rd_idx = j_ff + 6'd1;
         default:  rd_idx = '0;
      endcase
   end

   assign rd_wide = {{AW{1'b0}}, rd_idx};
   assign wr_wide = {{AW{1'b0}}, req_entry_index};
   assign wr_ok   = ({3'b0, req_entry_index} < MAX_W);

   bsti_ram #(
      .WIDTH (DATA_W),
      .DEPTH (MAX_ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_en && wr_ok),
      .wr_addr (wr_wide[AW-1:0]),
      .wr_data (req_entry_value),
      .rd_en   (cmd.rd_sel != RD_NONE),
      .rd_addr (rd_wide[AW-1:0]),
      .rd_data (rd_data)
   );

   assign sum   = prod_ff + PROD_W'(diff_ff);
   assign trial = {7'b0, den_ff} << k_ff;
   assign fits  = (rem_ff >= trial);

   assign status.n_small   = (n_live < DIRECT_BELOW);
   assign status.raw_le_rd = (raw_ff <= rd_data);
   assign status.raw_ge_rd = (raw_ff >= rd_data);
   assign status.j_last    = (j_ff == n_ff - 6'd1);
   assign status.div_last  = (k_ff == '0);

   always_comb begin
      case (cmd.res_sel)
         RES_DIRECT: percent_in = req_direct_percent;
         RES_ZERO:   percent_in = '0;
         RES_FULL:   percent_in = FULL_PERCENT;
         RES_QUOT:   percent_in = {1'b0, quot_ff};
         default:    percent_in = '0;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_en) begin
            count_ff <= csr_write_data;
         end
         rsp_valid_ff <= cmd.finish;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.cap) begin
         raw_ff <= req_raw_reading;
         n_ff   <= n_live;
      end
      if (cmd.keep_prev) begin
         prev_ff <= rd_data;
      end
      if (cmd.j_init) begin
         j_ff <= 6'd1;
      end else if (cmd.j_inc) begin
         j_ff <= j_ff + 6'd1;
      end
      if (cmd.take_seg) begin
         hi_ff <= rd_data;
         i_ff  <= j_ff - 6'd1;
      end
      if (cmd.calc_diff) begin
         d_ff    <= hi_ff - prev_ff;
         diff_ff <= raw_ff - prev_ff;
      end
      if (cmd.calc_mul) begin
         prod_ff <= PROD_W'(i_ff) * PROD_W'(d_ff);
         den_ff  <= PROD_W'(d_ff) * PROD_W'(n_ff - 6'd1);
      end
      if (cmd.calc_sum) begin
         rem_ff  <= {7'b0, sum} * {22'b0, SCALE};
         quot_ff <= '0;
         k_ff    <= TOP_STEP;
      end else if (cmd.div_step) begin
         if (fits) begin
            rem_ff  <= rem_ff - trial;
            quot_ff <= quot_ff | (7'd1 << k_ff);
         end
         k_ff <= k_ff - 3'd1;
      end
      if (cmd.finish) begin
         percent_ff <= percent_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_percent = percent_ff;

endmodule

`default_nettype wire

// ===== rtl/bsti_ctrl.sv =====
// ----------------------------------------------------------------------------
// bsti_ctrl - sequencer of the SoC table interpolator
// Write and direct requests, clamp checks, linear segment scan, multiply and divide steps.
// ----------------------------------------------------------------------------
`default_nettype none

module bsti_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic                    req_cmd,
   output      logic                    busy,
   output      bsti_pkg::dp_cmd_type    cmd,
   input  wire bsti_pkg::dp_status_type status
);

   import bsti_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FIRST,
      ST_LAST,
      ST_SCAN,
      ST_DIFF,
      ST_MUL,
      ST_SUM,
      ST_DIV,
      ST_DONE
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      busy_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.rd_sel  = RD_NONE;
      cmd.res_sel = RES_DIRECT;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_cmd == CMD_WRITE) begin
                  cmd.wr_en = 1'b1;
               end else begin
                  cmd.cap = 1'b1;
                  if (status.n_small) begin
                     cmd.finish  = 1'b1;
                     cmd.res_sel = RES_DIRECT;
                  end else begin
                     cmd.rd_sel = RD_FIRST;
                     state_in   = ST_FIRST;
                  end
               end
            end
         end
         ST_FIRST: begin
            if (status.raw_le_rd) begin
               cmd.finish  = 1'b1;
               cmd.res_sel = RES_ZERO;
               state_in    = ST_IDLE;
            end else begin
               cmd.keep_prev = 1'b1;
               cmd.rd_sel    = RD_LAST;
               state_in      = ST_LAST;
            end
         end
         ST_LAST: begin
            if (status.raw_ge_rd) begin
               cmd.finish  = 1'b1;
               cmd.res_sel = RES_FULL;
               state_in    = ST_IDLE;
            end else begin
               cmd.j_init = 1'b1;
               cmd.rd_sel = RD_ONE;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!status.raw_ge_rd || status.j_last) begin
               cmd.take_seg = 1'b1;
               state_in     = ST_DIFF;
            end else begin
               cmd.keep_prev = 1'b1;
               cmd.j_inc     = 1'b1;
               cmd.rd_sel    = RD_NEXT;
            end
         end
         ST_DIFF: begin
            cmd.calc_diff = 1'b1;
            state_in      = ST_MUL;
         end
         ST_MUL: begin
            cmd.calc_mul = 1'b1;
            state_in     = ST_SUM;
         end
         ST_SUM: begin
            cmd.calc_sum = 1'b1;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            cmd.finish  = 1'b1;
            cmd.res_sel = RES_QUOT;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= (state_in != ST_IDLE);
      end
   end

   assign busy = busy_ff;

endmodule

`default_nettype wire

// ===== rtl/bsti_checker.sv =====
// ----------------------------------------------------------------------------
// bsti_checker - port-level checks for the SoC table interpolator
// Request/result ordering as seen on the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none

module bsti_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic busy,
   input wire logic req_cmd,
   input wire logic rsp_valid
);

   // a write request produces no result
   assert property (@(posedge clock) disable iff (reset)
      start && !busy && !req_cmd |=> !rsp_valid)
      else $error("result after write request");

   // a query request either answers next cycle or holds busy
   assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_cmd |=> rsp_valid || busy)
      else $error("query request dropped");

   // the result strobe only comes while idle again
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result while busy");

   // leaving busy always delivers the result
   assert property (@(posedge clock) disable iff (reset)
      $fell(busy) && !$past(reset) |-> rsp_valid)
      else $error("busy ended without result");

endmodule

bind battery_soc_table_interpolator bsti_checker u_bsti_checker (.*);

`default_nettype wire

// ===== tb/sv/tb_battery_soc_table_interpolator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_battery_soc_table_interpolator - request/result check of the interpolator
// Loads calibration tables and sends percent queries through the start/busy
// port. Each accepted write updates a local table copy. Each query appends
// its predicted percent, and every rsp_valid strobe is compared against it.
// ----------------------------------------------------------------------------

module tb_battery_soc_table_interpolator;
   import bsti_pkg::*;

   localparam int TOTAL_ITEMS  = 1800;   // no new random phase starts once this many are sent
   localparam int TABLE_DEPTH  = MAX_ENTRIES_DEF;
   localparam int SETTLE_CYCLES = 4;     // writes leave busy low; small margin
   localparam int DRAIN_CYCLES = 80;     // longer than the longest query
   localparam int GAP_PERCENT  = 32;

   logic                clock = 1'b0;
   logic                reset;
   logic                start;
   logic                busy;
   logic                req_cmd;
   logic [CNT_W-1:0]    req_entry_index;
   logic [DATA_W-1:0]   req_entry_value;
   logic [DATA_W-1:0]   req_raw_reading;
   logic [PCT_W-1:0]    req_direct_percent;
   logic                rsp_valid;
   logic [PCT_W-1:0]    rsp_percent;
   logic                csr_write_en;
   logic [CNT_W-1:0]    csr_write_data;

   // local copy of the block's state
   logic [DATA_W-1:0]   soc_table [TABLE_DEPTH];
   logic [CNT_W-1:0]    entries_in_use;

   // percent values still owed by the block, oldest first
   logic [PCT_W-1:0]    expected_percent_q [$];

   int                  errors = 0;
   int                  requests_sent = 0;
   bit                  steady_stretch = 1'b0;   // suppresses sender gaps

   battery_soc_table_interpolator uut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_cmd            (req_cmd),
      .req_entry_index    (req_entry_index),
      .req_entry_value    (req_entry_value),
      .req_raw_reading    (req_raw_reading),
      .req_direct_percent (req_direct_percent),
      .rsp_valid          (rsp_valid),
      .rsp_percent        (rsp_percent),
      .csr_write_en       (csr_write_en),
      .csr_write_data     (csr_write_data)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Percent predictor
   // Direct gauge value below 11 entries; otherwise clamp at the table ends
   // and interpolate inside the first segment whose upper entry exceeds raw.
   // The scan always leaves c[seg] <= raw < c[seg+1], so the span is nonzero.
   // ---------------------------------------------------------------------
   function automatic logic [PCT_W-1:0] predict_percent(logic [DATA_W-1:0] raw,
                                                        logic [PCT_W-1:0] direct);
      int unsigned     n;
      int unsigned     seg;
      longint unsigned base;
      longint unsigned span;
      longint unsigned num;
      longint unsigned den;
      n = entries_in_use;
      if (n > TABLE_DEPTH) n = TABLE_DEPTH;
      if (n < DIRECT_BELOW) return direct;
      if (raw <= soc_table[0]) return '0;
      if (raw >= soc_table[n-1]) return FULL_PERCENT;
      seg = 0;
      while (seg + 1 < n - 1 && raw >= soc_table[seg+1]) seg++;
      base = soc_table[seg];
      span = longint'(soc_table[seg+1]) - base;
      num  = longint'(FULL_PERCENT) * (seg * span + (longint'(raw) - base));
      den  = span * (n - 1);
      return PCT_W'(num / den);
   endfunction

   // ---------------------------------------------------------------------
   // Result checker: each strobe is matched with the oldest prediction
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      logic [PCT_W-1:0] want;
      if (!reset && rsp_valid) begin
         if (expected_percent_q.size() == 0) begin
            $error("percent: no result expected, actual %0d", rsp_percent);
            errors++;
         end else begin
            want = expected_percent_q.pop_front();
            if (rsp_percent !== want) begin
               $error("percent: expected %0d, actual %0d", want, rsp_percent);
               errors++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Request driver. Entered at a falling edge; holds start until an edge
   // sees busy low, records the request, then maybe leaves a random gap.
   // Without a gap, start stays high so back-to-back requests keep it up.
   // ---------------------------------------------------------------------
   task automatic send_request(input logic cmd, input logic [CNT_W-1:0] idx,
                               input logic [DATA_W-1:0] val,
                               input logic [DATA_W-1:0] raw,
                               input logic [PCT_W-1:0] direct);
      start              <= 1'b1;
      req_cmd            <= cmd;
      req_entry_index    <= idx;
      req_entry_value    <= val;
      req_raw_reading    <= raw;
      req_direct_percent <= direct;
      do @(posedge clock); while (busy);
      // accepted at this edge
      if (cmd == CMD_WRITE) begin
         if (idx < TABLE_DEPTH) soc_table[idx] = val;
      end else begin
         expected_percent_q = {expected_percent_q, predict_percent(raw, direct)};
      end
      requests_sent++;
      @(negedge clock);
      if (!steady_stretch) begin
         while ($urandom_range(99) < GAP_PERCENT) begin
            start <= 1'b0;
            @(negedge clock);
         end
      end
   endtask

   task automatic write_entry(input int idx, input int val);
      send_request(CMD_WRITE, CNT_W'(idx), DATA_W'(val), DATA_W'($urandom),
                   PCT_W'($urandom));
   endtask

   task automatic query_percent(input int raw, input int direct);
      send_request(CMD_QUERY, CNT_W'($urandom), DATA_W'($urandom), DATA_W'(raw),
                   PCT_W'(direct));
   endtask

   // Drop start and wait until every owed result has arrived.
   task automatic wait_idle();
      start <= 1'b0;
      while (expected_percent_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // entry count is written only with the block idle
   task automatic set_entry_count(input int n);
      wait_idle();
      csr_write_en   <= 1'b1;
      csr_write_data <= CNT_W'(n);
      @(negedge clock);
      csr_write_en   <= 1'b0;
      entries_in_use = CNT_W'(n);
      @(negedge clock);
   endtask

   // Raw reading aimed at table entries, their neighbors and the ends
   function automatic logic [DATA_W-1:0] pick_raw(int n);
      int k;
      int lo;
      int hi;
      if (n < DIRECT_BELOW) return DATA_W'($urandom);
      k  = $urandom_range(0, n - 1);
      lo = soc_table[0];
      hi = soc_table[n-1];
      case ($urandom_range(0, 5))
         0: return DATA_W'($urandom);
         1: return soc_table[k];
         2: return soc_table[k] + 1'b1;
         3: return soc_table[k] - 1'b1;
         4: return $urandom_range(0, 1) ? '0 : '1;
         default: begin
            if (lo < hi) return DATA_W'($urandom_range(lo, hi));
            return DATA_W'($urandom);
         end
      endcase
   endfunction

   // Fill entries 0..n-1 with one of several table shapes
   task automatic load_table(input int n);
      int vals [TABLE_DEPTH];
      int shape;
      int base;
      int stride;
      int k;
      shape = $urandom_range(0, 7);
      base  = $urandom_range(0, 1000);
      stride = (65535 - base) / (n - 1);
      case (shape)
         0, 1, 2, 3: begin
            // strictly increasing; shape 3 spans the whole reading range
            if (shape == 3) base = 0;
            vals[0] = base;
            for (k = 1; k < n; k++) vals[k] = vals[k-1] + $urandom_range(1, stride);
            if (shape == 3) vals[n-1] = 65535;
         end
         4: begin
            // repeated entries, flat segments
            vals[0] = base;
            for (k = 1; k < n; k++) vals[k] = vals[k-1] + $urandom_range(0, stride);
         end
         5: begin
            // unordered table
            for (k = 0; k < n; k++) vals[k] = $urandom_range(0, 65535);
         end
         default: begin
            // very short segments
            vals[0] = $urandom_range(0, 60000);
            for (k = 1; k < n; k++) vals[k] = vals[k-1] + $urandom_range(1, 3);
         end
      endcase
      for (k = 0; k < n; k++) write_entry(k, vals[k]);
   endtask

   // ---------------------------------------------------------------------
   // Directed tests
   // ---------------------------------------------------------------------

   // fewer than 11 entries: the gauge's own percent comes straight back
   task automatic test_direct_mode();
      set_entry_count(0);
      query_percent(0, 0);
      query_percent(65535, 255);
      query_percent(16'h5A5A, 8'h5A);
      query_percent(16'hA5A5, 8'hA5);
      set_entry_count(10);
      query_percent($urandom_range(0, 65535), 100);
   endtask

   // 11-entry table over the full range: clamps, entry hits, top of last segment
   task automatic test_clamp_and_edges();
      int k;
      for (k = 0; k < 10; k++) write_entry(k, k * 6553);
      write_entry(10, 65535);
      set_entry_count(11);
      query_percent(0, $urandom);       // at first entry
      query_percent(65535, $urandom);   // at last entry
      query_percent(1, $urandom);
      query_percent(6553, $urandom);    // exactly on an inner entry
      query_percent(6554, $urandom);
      query_percent(65534, $urandom);   // just below the last entry
   endtask

   // repeated entry: the scan must skip the zero-width segment
   task automatic test_flat_segment();
      write_entry(3, 2 * 6553);
      query_percent(2 * 6553, $urandom);
   endtask

   // ---------------------------------------------------------------------
   // Random phases: new entry count, fresh table (or stray writes in
   // direct mode), then queries with occasional table rewrites mixed in
   // ---------------------------------------------------------------------
   task automatic test_random_tables();
      int phase;
      int n;
      int nq;
      int k;
      phase = 0;
      while (requests_sent < TOTAL_ITEMS) begin
         case (phase)
            0: n = 63;
            1: n = 11;
            default: begin
               case ($urandom_range(0, 9))
                  0, 1: n = $urandom_range(0, 10);
                  2:    n = 63;
                  3:    n = 11;
                  4:    n = 12;
                  default: n = $urandom_range(11, 63);
               endcase
            end
         endcase
         set_entry_count(n);
         steady_stretch = (phase % 6 == 3);
         if (n >= DIRECT_BELOW) begin
            load_table(n);
         end else begin
            repeat ($urandom_range(0, 3))
               write_entry($urandom_range(0, 63), $urandom_range(0, 65535));
         end
         nq = $urandom_range(15, 40);
         for (k = 0; k < nq; k++) begin
            if ($urandom_range(0, 9) == 0)
               write_entry($urandom_range(0, 63), $urandom_range(0, 65535));
            else
               query_percent(pick_raw(n), $urandom_range(0, 255));
         end
         steady_stretch = 1'b0;
         phase++;
      end
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      reset              = 1'b1;
      start              = 1'b0;
      req_cmd            = CMD_WRITE;
      req_entry_index    = '0;
      req_entry_value    = '0;
      req_raw_reading    = '0;
      req_direct_percent = '0;
      csr_write_en       = 1'b0;
      csr_write_data     = '0;
      entries_in_use     = '0;
      foreach (soc_table[k]) soc_table[k] = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_direct_mode();
      test_clamp_and_edges();
      test_flat_segment();
      test_random_tables();

      // drain: every owed result, then room for a stray late strobe
      start <= 1'b0;
      while (expected_percent_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // hang guard, several times the slowest legal run
   initial begin
      #5_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/bsti_pkg.sv
rtl/bsti_ram.sv
rtl/bsti_dp.sv
rtl/bsti_ctrl.sv
rtl/battery_soc_table_interpolator.sv
rtl/bsti_checker.sv
tb/sv/tb_battery_soc_table_interpolator.sv
